FILE: src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared constants, types and the quarter-wave sine generator
// Holds the fixed formats of the Clarke/Park transform and the elaboration
// time function that builds each entry of the quarter-wave sine table.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // Angle word: 65536 counts per electrical turn
    localparam int ANGLE_W = 16;

    // Sine/cosine word: signed, 32768 means 1.0
    localparam int TRIG_W = 17;
    localparam int TRIG_MAG_W = 16;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic [TRIG_MAG_W-1:0] trig_mag_t;

    // 1/sqrt3 in Q16
    localparam logic signed [16:0] INV_SQRT3_Q16 = 17'sd37837;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Rounding offsets
    localparam int ROUND_Q16 = 1 << 15;
    localparam int ROUND_Q15 = 1 << 14;

    // Entry k of a quarter-wave table of 2^tbits steps, Q15 magnitude.
    // Eight Taylor terms in Q30, each term built from the previous one.
    function automatic trig_mag_t quarter_sine(input int k, input int tbits);
        logic [63:0] x;
        logic [63:0] t;
        logic signed [63:0] sum;
        logic [63:0] r;
        x = (HALF_PI_Q30 * 64'(k)) >> tbits;
        t = x;
        sum = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (n)
                1:       t = t / 6;
                2:       t = t / 20;
                3:       t = t / 42;
                4:       t = t / 72;
                5:       t = t / 110;
                6:       t = t / 156;
                default: t = t / 210;
            endcase
            if ((n & 1) != 0)
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
        end
        if (sum < 0)
            sum = 64'sd0;
        r = ((64'(sum)) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (r > 64'd32768)
            r = 64'd32768;
        return r[TRIG_MAG_W-1:0];
    endfunction

endpackage

FILE: src/cpt_sincos.sv
// ----------------------------------------------------------------------------
// cpt_sincos: sine and cosine lookup
// Two-stage lookup: quarter-wave table read with quadrant fold, then sign.
// ----------------------------------------------------------------------------
module cpt_sincos #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                          clk,
    input  logic [cpt_pkg::ANGLE_W-1:0]   rotor_angle,
    output cpt_pkg::trig_t                sin_val,
    output cpt_pkg::trig_t                cos_val
);

    localparam int Q = 1 << SINE_TABLE_BITS;
    localparam int IDX_W = SINE_TABLE_BITS + 1;

    // Constant quarter-wave table, folded at elaboration
    cpt_pkg::trig_mag_t rom [0:Q];

    for (genvar k = 0; k <= Q; k++) begin : g_rom
        assign rom[k] = cpt_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end

    logic [SINE_TABLE_BITS-1:0] phase;
    logic [1:0]                 sin_quad;
    logic [1:0]                 cos_quad;
    logic [IDX_W-1:0]           idx_up;
    logic [IDX_W-1:0]           idx_down;
    logic [IDX_W-1:0]           sin_idx;
    logic [IDX_W-1:0]           cos_idx;

    cpt_pkg::trig_mag_t sin_mag_reg;
    cpt_pkg::trig_mag_t cos_mag_reg;
    logic               sin_neg_reg;
    logic               cos_neg_reg;
    cpt_pkg::trig_t     sin_reg;
    cpt_pkg::trig_t     cos_reg;
    cpt_pkg::trig_t     sin_next;
    cpt_pkg::trig_t     cos_next;

    // Fold the angle into a quarter-wave index; cosine leads by one quadrant
    always_comb
    begin
        phase    = rotor_angle[13 -: SINE_TABLE_BITS];
        sin_quad = rotor_angle[15:14];
        cos_quad = sin_quad + 2'd1;
        idx_up   = {1'b0, phase};
        idx_down = IDX_W'(Q) - idx_up;
        sin_idx  = sin_quad[0] ? idx_down : idx_up;
        cos_idx  = cos_quad[0] ? idx_down : idx_up;
    end

    // Read both magnitudes and hold the sign flags
    always_ff @(posedge clk)
    begin
        sin_mag_reg <= rom[sin_idx];
        cos_mag_reg <= rom[cos_idx];
        sin_neg_reg <= sin_quad[1];
        cos_neg_reg <= cos_quad[1];
    end

    // Apply the quadrant sign
    always_comb
    begin
        sin_next = $signed({1'b0, sin_mag_reg});
        cos_next = $signed({1'b0, cos_mag_reg});
        if (sin_neg_reg)
            sin_next = -sin_next;
        if (cos_neg_reg)
            cos_next = -cos_next;
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: src/cpt_clarke.sv
// ----------------------------------------------------------------------------
// cpt_clarke: two-phase Clarke transform
// Two stages: form a + 2b, then scale by 1/sqrt3 with round half up.
// ----------------------------------------------------------------------------
module cpt_clarke #(
    parameter int CURRENT_BITS = 16
) (
    input  logic                            clk,
    input  logic signed [CURRENT_BITS-1:0]  phase_a_current,
    input  logic signed [CURRENT_BITS-1:0]  phase_b_current,
    output logic signed [CURRENT_BITS-1:0]  alpha,
    output logic signed [CURRENT_BITS:0]    beta
);

    localparam int SUM_W  = CURRENT_BITS + 2;
    localparam int PROD_W = CURRENT_BITS + 19;

    logic signed [SUM_W-1:0]        apb_next;
    logic signed [SUM_W-1:0]        apb_reg;
    logic signed [CURRENT_BITS-1:0] alpha1_reg;
    logic signed [CURRENT_BITS-1:0] alpha2_reg;
    logic signed [PROD_W-1:0]       prod;
    logic signed [CURRENT_BITS:0]   beta_next;
    logic signed [CURRENT_BITS:0]   beta_reg;

    // Stage one: a + 2b
    assign apb_next = SUM_W'(phase_a_current) + (SUM_W'(phase_b_current) <<< 1);

    always_ff @(posedge clk)
    begin
        apb_reg    <= apb_next;
        alpha1_reg <= phase_a_current;
    end

    // Stage two: scale by 1/sqrt3, round half up, drop 16 fraction bits
    always_comb
    begin
        prod      = PROD_W'(apb_reg) * PROD_W'(cpt_pkg::INV_SQRT3_Q16)
                    + PROD_W'(cpt_pkg::ROUND_Q16);
        beta_next = $signed(prod[CURRENT_BITS+16:16]);
    end

    always_ff @(posedge clk)
    begin
        beta_reg   <= beta_next;
        alpha2_reg <= alpha1_reg;
    end

    assign alpha = alpha2_reg;
    assign beta  = beta_reg;

endmodule

FILE: src/cpt_park.sv
// ----------------------------------------------------------------------------
// cpt_park: Park rotation
// Two stages: four products in parallel, then sums, rounding and saturation.
// ----------------------------------------------------------------------------
module cpt_park #(
    parameter int CURRENT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [CURRENT_BITS-1:0]  alpha,
    input  logic signed [CURRENT_BITS:0]    beta,
    input  cpt_pkg::trig_t                  sin_val,
    input  cpt_pkg::trig_t                  cos_val,
    output logic                            out_valid,
    output logic signed [CURRENT_BITS+1:0]  direct_current,
    output logic signed [CURRENT_BITS+1:0]  quadrature_current
);

    localparam int PROD_W = CURRENT_BITS + cpt_pkg::TRIG_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SUM_W - 15;
    localparam int OUT_W  = CURRENT_BITS + 2;
    localparam logic signed [SH_W-1:0] OUT_HI = SH_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [SH_W-1:0] OUT_LO = -OUT_HI - SH_W'(1);

    logic signed [PROD_W-1:0] p_ac_reg;
    logic signed [PROD_W-1:0] p_bs_reg;
    logic signed [PROD_W-1:0] p_bc_reg;
    logic signed [PROD_W-1:0] p_as_reg;
    logic                     v3_reg;
    logic                     v4_reg;

    logic signed [SUM_W-1:0]  d_sum;
    logic signed [SUM_W-1:0]  q_sum;
    logic signed [SH_W-1:0]   d_sh;
    logic signed [SH_W-1:0]   q_sh;
    logic signed [OUT_W-1:0]  d_next;
    logic signed [OUT_W-1:0]  q_next;
    logic signed [OUT_W-1:0]  d_reg;
    logic signed [OUT_W-1:0]  q_reg;

    // Clamp to the output range
    function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [SH_W-1:0] v);
        logic signed [SH_W-1:0] r;
        r = v;
        if (v > OUT_HI)
            r = OUT_HI;
        else if (v < OUT_LO)
            r = OUT_LO;
        return r[OUT_W-1:0];
    endfunction

    // Stage three: form the four rotation products
    always_ff @(posedge clk)
    begin
        p_ac_reg <= PROD_W'(alpha) * PROD_W'(cos_val);
        p_bs_reg <= PROD_W'(beta) * PROD_W'(sin_val);
        p_bc_reg <= PROD_W'(beta) * PROD_W'(cos_val);
        p_as_reg <= PROD_W'(alpha) * PROD_W'(sin_val);
    end

    // Stage four: combine, round half up, drop 15 fraction bits, clamp
    always_comb
    begin
        d_sum  = SUM_W'(p_ac_reg) + SUM_W'(p_bs_reg) + SUM_W'(cpt_pkg::ROUND_Q15);
        q_sum  = SUM_W'(p_bc_reg) - SUM_W'(p_as_reg) + SUM_W'(cpt_pkg::ROUND_Q15);
        d_sh   = $signed(d_sum[SUM_W-1:15]);
        q_sh   = $signed(q_sum[SUM_W-1:15]);
        d_next = clamp_out(d_sh);
        q_next = clamp_out(q_sh);
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        q_reg <= q_next;
    end

    // Advance the valid marks with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid          = v4_reg;
    assign direct_current     = d_reg;
    assign quadrature_current = q_reg;

endmodule

FILE: src/clarke_park_current_transform_core.sv
// ----------------------------------------------------------------------------
// clarke_park_current_transform_core: phase currents to d/q currents
// A request (start high while busy is low) carries two phase currents and an
// electrical angle. When it leaves the pipeline, done is high for one cycle
// with direct_current and quadrature_current, in request order. The datapath
// is a four-stage pipeline (table lookup and a + 2b, 1/sqrt3 scaling and sign,
// four parallel rotation products, rounding and clamp), so one request is
// taken every clock; busy is always low and the receiver must take each
// result in the cycle it is shown.
// ----------------------------------------------------------------------------
module clarke_park_current_transform_core #(
    parameter int SINE_TABLE_BITS = 8,
    parameter int CURRENT_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [CURRENT_BITS-1:0]  phase_a_current,
    input  logic signed [CURRENT_BITS-1:0]  phase_b_current,
    input  logic [cpt_pkg::ANGLE_W-1:0]     rotor_angle,
    output logic                            done,
    output logic signed [CURRENT_BITS+1:0]  direct_current,
    output logic signed [CURRENT_BITS+1:0]  quadrature_current
);

    logic                           v1_reg;
    logic                           v2_reg;
    logic signed [CURRENT_BITS-1:0] alpha;
    logic signed [CURRENT_BITS:0]   beta;
    cpt_pkg::trig_t                 sin_val;
    cpt_pkg::trig_t                 cos_val;

    // Pipeline never stalls
    assign busy = 1'b0;

    // Track valid requests through the lookup and Clarke stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    cpt_sincos #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sincos (
        .clk         (clk),
        .rotor_angle (rotor_angle),
        .sin_val     (sin_val),
        .cos_val     (cos_val)
    );

    cpt_clarke #(
        .CURRENT_BITS (CURRENT_BITS)
    ) u_clarke (
        .clk             (clk),
        .phase_a_current (phase_a_current),
        .phase_b_current (phase_b_current),
        .alpha           (alpha),
        .beta            (beta)
    );

    cpt_park #(
        .CURRENT_BITS (CURRENT_BITS)
    ) u_park (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (v2_reg),
        .alpha              (alpha),
        .beta               (beta),
        .sin_val            (sin_val),
        .cos_val            (cos_val),
        .out_valid          (done),
        .direct_current     (direct_current),
        .quadrature_current (quadrature_current)
    );

endmodule

FILE: tb/tb_clarke_park_current_transform_core.sv
// ----------------------------------------------------------------------------
// tb_clarke_park_current_transform_core: d/q current transform testbench
// Drives phase current pairs and electrical angles into the core, predicts the
// rounded d and q currents from a quarter-wave sine table built here, and
// checks every result in request order. Directed corner requests come first,
// then random requests with random sender gaps and a few full drains.
// ----------------------------------------------------------------------------
module tb_clarke_park_current_transform_core;

    localparam int TABLE_BITS  = 8;
    localparam int QUARTER     = 1 << TABLE_BITS;
    localparam int CUR_W       = 16;
    localparam int DQ_W        = CUR_W + 2;
    localparam int RANDOM_REQS = 1950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 12;

    localparam longint DQ_MAX = (64'sd1 <<< (DQ_W - 1)) - 1;
    localparam longint DQ_MIN = -(64'sd1 <<< (DQ_W - 1));

    typedef struct {
        logic signed [CUR_W-1:0]         a;
        logic signed [CUR_W-1:0]         b;
        logic [cpt_pkg::ANGLE_W-1:0]     angle;
        int                              gap;
        bit                              drain;
    } current_req_t;

    typedef struct {
        logic signed [DQ_W-1:0] d;
        logic signed [DQ_W-1:0] q;
    } dq_pair_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic signed [CUR_W-1:0]         phase_a_current = '0;
    logic signed [CUR_W-1:0]         phase_b_current = '0;
    logic [cpt_pkg::ANGLE_W-1:0]     rotor_angle = '0;
    logic                            done;
    logic signed [DQ_W-1:0]          direct_current;
    logic signed [DQ_W-1:0]          quadrature_current;

    current_req_t pending_requests[$];
    dq_pair_t     expected_dq[$];
    longint       sine_q15[0:QUARTER];
    int           hold_cycles = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    clarke_park_current_transform_core #(
        .SINE_TABLE_BITS (TABLE_BITS),
        .CURRENT_BITS    (CUR_W)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .phase_a_current    (phase_a_current),
        .phase_b_current    (phase_b_current),
        .rotor_angle        (rotor_angle),
        .done               (done),
        .direct_current     (direct_current),
        .quadrature_current (quadrature_current)
    );

    // Clock: period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sine of k table steps within a quarter turn in Q15: eight Taylor terms in Q30
    function automatic longint taylor_sine_q15(input int k);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint unsigned rounded;
        x = (64'd1686629713 * longint'(k)) >> TABLE_BITS;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (longint'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (rounded > 64'd32768)
            rounded = 64'd32768;
        return longint'(rounded);
    endfunction

    // Signed sine of a 16-bit turn fraction from the quarter-wave table
    function automatic longint angle_sine(input logic [15:0] angle);
        int     idx;
        longint mag;
        idx = int'(angle[13:0]) >> (14 - TABLE_BITS);
        mag = angle[14] ? sine_q15[QUARTER - idx] : sine_q15[idx];
        return angle[15] ? -mag : mag;
    endfunction

    function automatic longint clamp_dq(input longint v);
        if (v > DQ_MAX)
            return DQ_MAX;
        if (v < DQ_MIN)
            return DQ_MIN;
        return v;
    endfunction

    // Clarke then Park, each product sum rounded half up
    function automatic dq_pair_t predict_dq(input logic signed [CUR_W-1:0] a_in,
                                            input logic signed [CUR_W-1:0] b_in,
                                            input logic [15:0] angle);
        longint   alpha;
        longint   beta;
        longint   sn;
        longint   cs;
        dq_pair_t res;
        alpha = longint'(a_in);
        beta = ((alpha + 2 * longint'(b_in)) * 37837 + 32768) >>> 16;
        sn = angle_sine(angle);
        cs = angle_sine(angle + 16'd16384);
        res.d = DQ_W'(clamp_dq((alpha * cs + beta * sn + 16384) >>> 15));
        res.q = DQ_W'(clamp_dq((beta * cs - alpha * sn + 16384) >>> 15));
        return res;
    endfunction

    // Random current, leaning on the extremes now and then
    function automatic logic signed [CUR_W-1:0] draw_current();
        case ($urandom_range(0, 11))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return CUR_W'($urandom);
        endcase
    endfunction

    // Random angle, sometimes right at a quadrant or table step boundary
    function automatic logic [15:0] draw_angle();
        logic [15:0] base;
        base = 16'($urandom_range(0, 3)) << 14;
        case ($urandom_range(0, 7))
            0:       return base;
            1:       return base - 16'd1;
            2:       return base + 16'($urandom_range(0, 63));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_request(input logic signed [CUR_W-1:0] a_in,
                               input logic signed [CUR_W-1:0] b_in,
                               input logic [15:0] angle,
                               input int gap,
                               input bit drain);
        current_req_t r;
        r.a = a_in;
        r.b = b_in;
        r.angle = angle;
        r.gap = gap;
        r.drain = drain;
        pending_requests.push_back(r);
    endtask

    // Driver: record accepted requests, then present the next one after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            hold_cycles <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_dq.push_back(predict_dq(phase_a_current, phase_b_current,
                                                 rotor_angle));
            if (!start || !busy)
            begin
                if (hold_cycles > 0)
                begin
                    hold_cycles <= hold_cycles - 1;
                    start <= 1'b0;
                end
                else if (pending_requests.size() == 0)
                    start <= 1'b0;
                else if (pending_requests[0].drain &&
                         (expected_dq.size() != 0 || start))
                    start <= 1'b0;
                else
                begin
                    phase_a_current <= pending_requests[0].a;
                    phase_b_current <= pending_requests[0].b;
                    rotor_angle <= pending_requests[0].angle;
                    start <= 1'b1;
                    void'(pending_requests.pop_front());
                    hold_cycles <= (pending_requests.size() != 0) ?
                                   pending_requests[0].gap : 0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_dq.size() == 0)
            begin
                $error("unexpected result d=%0d q=%0d", direct_current,
                       quadrature_current);
                error_count = error_count + 1;
            end
            else
            begin
                if (direct_current !== expected_dq[0].d)
                begin
                    $error("direct_current: expected %0d, actual %0d",
                           expected_dq[0].d, direct_current);
                    error_count = error_count + 1;
                end
                if (quadrature_current !== expected_dq[0].q)
                begin
                    $error("quadrature_current: expected %0d, actual %0d",
                           expected_dq[0].q, quadrature_current);
                    error_count = error_count + 1;
                end
                void'(expected_dq.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("clarke_park_current_transform_core test failed");
            $finish;
        end
    end

    initial
    begin
        bit bursty;
        for (int k = 0; k <= QUARTER; k++)
            sine_q15[k] = taylor_sine_q15(k);

        // Directed: current extremes against every quadrant and table edges
        add_request(16'sh7FFF, 16'sh7FFF, 16'd0,     0, 1'b0);
        add_request(16'sh8000, 16'sh8000, 16'd16384, 0, 1'b0);
        add_request(16'sh7FFF, 16'sh8000, 16'd32768, 0, 1'b0);
        add_request(16'sh8000, 16'sh7FFF, 16'd49152, 0, 1'b0);
        add_request(16'sh0000, 16'sh0000, 16'd65535, 1, 1'b0);
        add_request(16'shFFFF, 16'shFFFF, 16'd63,    0, 1'b0);
        add_request(16'sh7FFF, 16'sh0000, 16'd64,    2, 1'b0);
        add_request(16'sh0000, 16'sh7FFF, 16'd16383, 0, 1'b0);
        add_request(16'sh8000, 16'sh0000, 16'd8192,  0, 1'b0);
        add_request(16'sh0000, 16'sh8000, 16'd24576, 3, 1'b0);
        add_request(16'sh7FFF, 16'shC000, 16'd40960, 0, 1'b0);
        add_request(16'sh8000, 16'sh4000, 16'd57344, 0, 1'b0);
        add_request(16'sh4000, 16'sh4000, 16'd32767, 0, 1'b0);
        add_request(16'shC000, 16'shC000, 16'd49151, 1, 1'b0);
        add_request(16'sh0001, 16'shFFFF, 16'd5461,  0, 1'b0);
        add_request(16'sh8000, 16'sh8000, 16'd60075, 0, 1'b0);
        add_request(16'sh7FFF, 16'sh7FFF, 16'd10923, 0, 1'b0);
        add_request(16'sh5A5A, 16'shA5A5, 16'd43690, 0, 1'b0);
        add_request(16'sh0001, 16'sh0001, 16'd21845, 0, 1'b1);

        // Random: back-to-back stretches mixed at random with gappy ones
        bursty = 1'b1;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % 120 == 0)
                bursty = ($urandom_range(0, 2) == 0);
            add_request(draw_current(), draw_current(), draw_angle(),
                        bursty ? 0 : $urandom_range(0, 8), (i % 250 == 249));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last request to go in, then for its result
        while (pending_requests.size() != 0 || start)
            @(negedge clk);
        while (expected_dq.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (error_count == 0)
            $display("clarke_park_current_transform_core test passed");
        else
            $display("clarke_park_current_transform_core test failed");
        $finish;
    end

endmodule

FILE: clarke_park_current_transform_core.f
src/cpt_pkg.sv
src/cpt_sincos.sv
src/cpt_clarke.sv
src/cpt_park.sv
src/clarke_park_current_transform_core.sv
tb/tb_clarke_park_current_transform_core.sv
